### src/scfp_pkg.sv
`default_nettype none

package scfp_pkg;

    localparam int PAYLOAD_DEPTH = 32;
    localparam int ADDR_W        = $clog2(PAYLOAD_DEPTH);
    localparam int BYTE_W        = 8;
    localparam int LEN_W         = 6;
    localparam int KIND_W        = 2;

    localparam logic [LEN_W-1:0] DEPTH_LEN = LEN_W'(PAYLOAD_DEPTH);

    // header characters
    localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
    localparam logic [BYTE_W-1:0] CH_EM     = 8'h4D;
    localparam logic [BYTE_W-1:0] CH_ARROW  = 8'h3C;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_HEADER  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ERROR   = 2'd2;

endpackage

`default_nettype wire

### src/scfp_if.sv
`default_nettype none

interface scfp_rx_if;
    logic                          valid;
    logic                          ready;
    logic [scfp_pkg::BYTE_W-1:0]   rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface scfp_res_if;
    logic                          valid;
    logic                          ready;
    logic [scfp_pkg::KIND_W-1:0]   kind;
    logic [scfp_pkg::BYTE_W-1:0]   command;
    logic [scfp_pkg::LEN_W-1:0]    length;
    logic [scfp_pkg::BYTE_W-1:0]   data;
    logic                          last;

    modport source (output valid, output kind, output command, output length,
                    output data, output last, input ready);
    modport sink   (input valid, input kind, input command, input length,
                    input data, input last, output ready);
endinterface

`default_nettype wire

### src/serial_command_frame_parser.sv
`default_nettype none

// channel     dir  payload                              handshake
// ---------   ---  -----------------------------------  ---------------------
// rx          in   rx_byte                              valid/ready
// result      out  kind, command, length, data, last    valid/ready
// cfg         in   cfg_wdata (size_limit)               cfg_we, no wait
//
// one received byte per cycle while parsing header, size, command and body
// a good checksum loads the header result, then payload bytes are read back
// from the payload memory one by one, each read and then loaded into the output slot
// rx is held off during that readout, and on the checksum byte while the
// output slot is still full; otherwise bytes flow while a result waits
// reset clears control state only; the payload memory has no clearing pass

module serial_command_frame_parser (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    scfp_rx_if.sink                            rx,
    scfp_res_if.source                         result,
    input  wire logic                          cfg_we,
    input  wire logic [scfp_pkg::LEN_W-1:0]    cfg_wdata
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_DOLLAR,
        PH_EM,
        PH_ARROW,
        PH_SIZE,
        PH_BODY,
        PH_EMIT_RD,
        PH_EMIT_WAIT
    } phase_t;

    phase_t                          phase_reg, phase_next;
    logic [scfp_pkg::LEN_W-1:0]      size_limit_reg, size_limit_next;
    logic [scfp_pkg::BYTE_W-1:0]     xor_reg, xor_next;
    logic [scfp_pkg::BYTE_W-1:0]     command_reg, command_next;
    logic [scfp_pkg::LEN_W-1:0]      length_reg, length_next;
    logic [scfp_pkg::LEN_W-1:0]      fill_reg, fill_next;
    logic [scfp_pkg::LEN_W-1:0]      emit_idx_reg, emit_idx_next;

    // output slot
    logic                            out_valid_reg, out_valid_next;
    logic [scfp_pkg::KIND_W-1:0]     out_kind_reg, out_kind_next;
    logic [scfp_pkg::BYTE_W-1:0]     out_command_reg, out_command_next;
    logic [scfp_pkg::LEN_W-1:0]      out_length_reg, out_length_next;
    logic [scfp_pkg::BYTE_W-1:0]     out_data_reg, out_data_next;
    logic                            out_last_reg, out_last_next;

    // payload memory, single write port and registered read
    logic [scfp_pkg::BYTE_W-1:0]     payload_mem [scfp_pkg::PAYLOAD_DEPTH];
    logic [scfp_pkg::BYTE_W-1:0]     mem_q;
    logic                            mem_we;
    logic                            mem_re;
    logic [scfp_pkg::ADDR_W-1:0]     mem_waddr;
    logic [scfp_pkg::ADDR_W-1:0]     mem_raddr;

    logic                            slot_free;
    logic                            body_done;
    logic                            in_ready;
    logic                            in_fire;
    logic [scfp_pkg::LEN_W-1:0]      limit;
    logic [scfp_pkg::BYTE_W-1:0]     c;

    assign c         = rx.rx_byte;
    assign slot_free = !out_valid_reg || result.ready;
    assign body_done = (phase_reg == PH_BODY) && (fill_reg == length_reg);

    // effective limit saturates at the memory depth
    assign limit = (size_limit_reg > scfp_pkg::DEPTH_LEN) ? scfp_pkg::DEPTH_LEN
                                                          : size_limit_reg;

    // checksum byte needs the output slot; readout blocks rx entirely
    always_comb
    begin
        case (phase_reg)
            PH_IDLE, PH_DOLLAR, PH_EM, PH_ARROW, PH_SIZE:
                in_ready = 1'b1;
            PH_BODY:
                in_ready = !body_done || slot_free;
            default:
                in_ready = 1'b0;
        endcase
    end

    assign in_fire  = rx.valid && in_ready;
    assign rx.ready = in_ready;

    assign result.valid   = out_valid_reg;
    assign result.kind    = out_kind_reg;
    assign result.command = out_command_reg;
    assign result.length  = out_length_reg;
    assign result.data    = out_data_reg;
    assign result.last    = out_last_reg;

    // writes happen only in the body, reads only in the readout, so the two
    // ports never touch the same entry in the same cycle
    assign mem_waddr = fill_reg[scfp_pkg::ADDR_W-1:0];
    assign mem_raddr = emit_idx_reg[scfp_pkg::ADDR_W-1:0];

    always_comb
    begin
        phase_next       = phase_reg;
        size_limit_next  = cfg_we ? cfg_wdata : size_limit_reg;
        xor_next         = xor_reg;
        command_next     = command_reg;
        length_next      = length_reg;
        fill_next        = fill_reg;
        emit_idx_next    = emit_idx_reg;
        out_valid_next   = out_valid_reg && !result.ready;
        out_kind_next    = out_kind_reg;
        out_command_next = out_command_reg;
        out_length_next  = out_length_reg;
        out_data_next    = out_data_reg;
        out_last_next    = out_last_reg;
        mem_we           = 1'b0;
        mem_re           = 1'b0;

        case (phase_reg)
            PH_IDLE:
            begin
                if (in_fire)
                begin
                    phase_next = (c == scfp_pkg::CH_DOLLAR) ? PH_DOLLAR : PH_IDLE;
                end
            end
            PH_DOLLAR:
            begin
                if (in_fire)
                begin
                    phase_next = (c == scfp_pkg::CH_EM) ? PH_EM : PH_IDLE;
                end
            end
            PH_EM:
            begin
                if (in_fire)
                begin
                    phase_next = (c == scfp_pkg::CH_ARROW) ? PH_ARROW : PH_IDLE;
                end
            end
            PH_ARROW:
            begin
                if (in_fire)
                begin
                    // oversize frames are dropped silently
                    if (c > {2'b00, limit})
                    begin
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        length_next = c[scfp_pkg::LEN_W-1:0];
                        fill_next   = '0;
                        xor_next    = c;
                        phase_next  = PH_SIZE;
                    end
                end
            end
            PH_SIZE:
            begin
                if (in_fire)
                begin
                    command_next = c;
                    xor_next     = xor_reg ^ c;
                    phase_next   = PH_BODY;
                end
            end
            PH_BODY:
            begin
                if (in_fire)
                begin
                    if (!body_done)
                    begin
                        xor_next  = xor_reg ^ c;
                        mem_we    = 1'b1;
                        fill_next = fill_reg + 1'b1;
                    end
                    else
                    begin
                        out_valid_next   = 1'b1;
                        out_command_next = command_reg;
                        out_length_next  = length_reg;
                        out_data_next    = '0;
                        if (xor_reg == c)
                        begin
                            out_kind_next = scfp_pkg::KIND_HEADER;
                            out_last_next = (length_reg == '0);
                            fill_next     = '0;
                            emit_idx_next = '0;
                            phase_next    = (length_reg == '0) ? PH_IDLE : PH_EMIT_RD;
                        end
                        else
                        begin
                            out_kind_next = scfp_pkg::KIND_ERROR;
                            out_last_next = 1'b1;
                            phase_next    = PH_IDLE;
                        end
                    end
                end
            end
            PH_EMIT_RD:
            begin
                mem_re     = 1'b1;
                phase_next = PH_EMIT_WAIT;
            end
            PH_EMIT_WAIT:
            begin
                // mem_q holds the byte until the slot frees up
                if (slot_free)
                begin
                    out_valid_next   = 1'b1;
                    out_kind_next    = scfp_pkg::KIND_PAYLOAD;
                    out_command_next = command_reg;
                    out_length_next  = length_reg;
                    out_data_next    = mem_q;
                    out_last_next    = (emit_idx_reg + 1'b1 == length_reg);
                    emit_idx_next    = emit_idx_reg + 1'b1;
                    phase_next       = (emit_idx_reg + 1'b1 == length_reg) ? PH_IDLE
                                                                         : PH_EMIT_RD;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            size_limit_reg  <= scfp_pkg::DEPTH_LEN;
            xor_reg         <= '0;
            command_reg     <= '0;
            length_reg      <= '0;
            fill_reg        <= '0;
            emit_idx_reg    <= '0;
            out_valid_reg   <= 1'b0;
            out_kind_reg    <= scfp_pkg::KIND_HEADER;
            out_command_reg <= '0;
            out_length_reg  <= '0;
            out_data_reg    <= '0;
            out_last_reg    <= 1'b0;
        end
        else
        begin
            phase_reg       <= phase_next;
            size_limit_reg  <= size_limit_next;
            xor_reg         <= xor_next;
            command_reg     <= command_next;
            length_reg      <= length_next;
            fill_reg        <= fill_next;
            emit_idx_reg    <= emit_idx_next;
            out_valid_reg   <= out_valid_next;
            out_kind_reg    <= out_kind_next;
            out_command_reg <= out_command_next;
            out_length_reg  <= out_length_next;
            out_data_reg    <= out_data_next;
            out_last_reg    <= out_last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            payload_mem[mem_waddr] <= c;
        end
        if (mem_re)
        begin
            mem_q <= payload_mem[mem_raddr];
        end
    end

endmodule

`default_nettype wire

### bench/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import scfp_pkg::*;

    // one item of the result channel, field by field
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] command;
        logic [LEN_W-1:0]  length;
        logic [BYTE_W-1:0] data;
        logic              last;
    } parse_result_t;

    // where the parser stands in the frame
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_DOLLAR,
        PH_EM,
        PH_ARROW,
        PH_SIZE,
        PH_BODY
    } parse_phase_t;

    // one row of the directed table; typed rows carry their result spelled out
    typedef struct packed {
        logic [BYTE_W-1:0] rx_byte;
        logic              typed;
        logic              has_result;
        parse_result_t     res;
    } directed_row_t;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 9;
    localparam int STALL_LIMIT  = 2000;  // cycles with no item moving on either side
    localparam int SETTLE       = 8;     // pause before a size_limit write
    localparam int DRAIN        = 80;    // cycles after the last expected result
    localparam int PHASE_ITEMS  = 72;    // counted rx items per random phase
    localparam int NUM_PHASES   = 6;

    // directed part: header break, empty frame, oversize, bad checksum, one-byte frame
    localparam directed_row_t DIRECTED [28] = '{
        // a '$' that breaks the header is consumed and does not restart matching
        '{CH_DOLLAR, 1'b1, 1'b0, '0},
        '{CH_DOLLAR, 1'b1, 1'b0, '0},
        '{CH_EM,     1'b1, 1'b0, '0},
        '{CH_ARROW,  1'b1, 1'b0, '0},
        // empty payload, command all ones: header result only, marked last
        '{CH_DOLLAR, 1'b1, 1'b0, '0},
        '{CH_EM,     1'b1, 1'b0, '0},
        '{CH_ARROW,  1'b1, 1'b0, '0},
        '{8'h00,     1'b1, 1'b0, '0},
        '{8'hFF,     1'b1, 1'b0, '0},
        '{8'hFF,     1'b1, 1'b1, '{KIND_HEADER, 8'hFF, 6'd0, 8'h00, 1'b1}},
        // size one above the reset limit is dropped silently
        '{CH_DOLLAR, 1'b1, 1'b0, '0},
        '{CH_EM,     1'b1, 1'b0, '0},
        '{CH_ARROW,  1'b1, 1'b0, '0},
        '{8'h21,     1'b1, 1'b0, '0},
        // checksum off by one: single error result
        '{CH_DOLLAR, 1'b1, 1'b0, '0},
        '{CH_EM,     1'b1, 1'b0, '0},
        '{CH_ARROW,  1'b1, 1'b0, '0},
        '{8'h01,     1'b1, 1'b0, '0},
        '{8'h80,     1'b1, 1'b0, '0},
        '{8'hAA,     1'b1, 1'b0, '0},
        '{8'h2C,     1'b1, 1'b1, '{KIND_ERROR, 8'h80, 6'd1, 8'h00, 1'b1}},
        // one payload byte, command zero, good checksum
        '{CH_DOLLAR, 1'b0, 1'b0, '0},
        '{CH_EM,     1'b0, 1'b0, '0},
        '{CH_ARROW,  1'b0, 1'b0, '0},
        '{8'h01,     1'b0, 1'b0, '0},
        '{8'h00,     1'b0, 1'b0, '0},
        '{8'hFF,     1'b0, 1'b0, '0},
        '{8'hFE,     1'b0, 1'b0, '0}
    };

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [LEN_W-1:0]  cfg_wdata;

    scfp_rx_if  rx_ch ();
    scfp_res_if res_ch ();

    serial_command_frame_parser uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx        (rx_ch),
        .result    (res_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // parser shadow state
    parse_phase_t      phase_m;
    logic [BYTE_W-1:0] xor_m;
    logic [BYTE_W-1:0] cmd_m;
    logic [LEN_W-1:0]  len_m;
    logic [LEN_W-1:0]  fill_m;
    logic [LEN_W-1:0]  limit_m;
    logic [BYTE_W-1:0] store_m [PAYLOAD_DEPTH];

    parse_result_t     frame_results [$];    // results of the byte just taken
    parse_result_t     pending_results [$];  // results still owed by the block
    logic [BYTE_W-1:0] burst [$];            // bytes of the next random sequence
    int                mismatches = 0;
    int                quiet_cycles = 0;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // mostly short idle stretches, now and then a long one
    function automatic int unsigned pick_idle_cycles();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 80)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic parse_result_t make_result(input logic [KIND_W-1:0] kind,
                                                  input logic [BYTE_W-1:0] data,
                                                  input logic last);
        parse_result_t r;
        r.kind    = kind;
        r.command = cmd_m;
        r.length  = len_m;
        r.data    = data;
        r.last    = last;
        return r;
    endfunction

    // advance the shadow parser by one rx byte, results go to frame_results
    function automatic void parse_rx_byte(input logic [BYTE_W-1:0] b);
        logic [LEN_W-1:0] eff_limit;
        int               i;
        // limits above the payload memory saturate at its depth
        eff_limit = (limit_m > DEPTH_LEN) ? DEPTH_LEN : limit_m;
        case (phase_m)
            PH_IDLE:   phase_m = (b == CH_DOLLAR) ? PH_DOLLAR : PH_IDLE;
            PH_DOLLAR: phase_m = (b == CH_EM) ? PH_EM : PH_IDLE;
            PH_EM:     phase_m = (b == CH_ARROW) ? PH_ARROW : PH_IDLE;
            PH_ARROW:
            begin
                if (b > eff_limit)
                begin
                    phase_m = PH_IDLE;
                end
                else
                begin
                    len_m   = b[LEN_W-1:0];
                    fill_m  = '0;
                    xor_m   = b;
                    phase_m = PH_SIZE;
                end
            end
            PH_SIZE:
            begin
                cmd_m   = b;
                xor_m   = xor_m ^ b;
                phase_m = PH_BODY;
            end
            PH_BODY:
            begin
                if (fill_m < len_m)
                begin
                    xor_m = xor_m ^ b;
                    if (fill_m < DEPTH_LEN)
                        store_m[fill_m[ADDR_W-1:0]] = b;
                    fill_m = fill_m + 1'b1;
                end
                else if (xor_m == b)
                begin
                    // good frame: header, then the payload in order
                    frame_results.push_back(make_result(KIND_HEADER, '0, len_m == 0));
                    for (i = 0; i < len_m; i++)
                        frame_results.push_back(make_result(KIND_PAYLOAD, store_m[i],
                                                            i + 1 == len_m));
                    fill_m  = '0;
                    phase_m = PH_IDLE;
                end
                else
                begin
                    frame_results.push_back(make_result(KIND_ERROR, '0, 1'b1));
                    phase_m = PH_IDLE;
                end
            end
            default:   phase_m = PH_IDLE;
        endcase
    endfunction

    // offer one rx item, wait for the handshake, book its results, then maybe idle
    task automatic drive_byte(input logic [BYTE_W-1:0] b, input logic typed,
                              input logic has_result, input parse_result_t res,
                              input bit no_gaps);
        int unsigned gap;
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        do
            @(posedge clk);
        while (rx_ch.ready !== 1'b1);
        parse_rx_byte(b);
        if (typed)
        begin
            // table row: the spelled-out result replaces the shadow parser's
            frame_results.delete();
            if (has_result)
                pending_results.push_back(res);
        end
        else
        begin
            while (frame_results.size() != 0)
                pending_results.push_back(frame_results.pop_front());
        end
        gap = no_gaps ? 0 : pick_idle_cycles();
        if (gap != 0)
        begin
            rx_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // size_limit is only written with the block drained and rx quiet
    task automatic write_size_limit(input logic [LEN_W-1:0] value);
        rx_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we  <= 1'b0;
        limit_m = value;
    endtask

    // build one random byte sequence into burst; counted excludes idle noise
    task automatic queue_random_sequence(output int unsigned counted);
        int unsigned       pick;
        int unsigned       r;
        int unsigned       eff_limit;
        int unsigned       size;
        int unsigned       k;
        int unsigned       i;
        logic [BYTE_W-1:0] cmd;
        logic [BYTE_W-1:0] b;
        logic [BYTE_W-1:0] cks;
        burst.delete();
        eff_limit = (limit_m > DEPTH_LEN) ? PAYLOAD_DEPTH : limit_m;
        pick = $urandom_range(0, 99);
        if (pick < 70)
        begin
            // well-formed frame, mostly short payloads, now and then the largest
            r = $urandom_range(0, 99);
            if (r < 8)
                size = eff_limit;
            else if (r < 18)
                size = 0;
            else
                size = $urandom_range(0, (eff_limit < 6) ? eff_limit : 6);
            cmd = BYTE_W'($urandom);
            burst = '{CH_DOLLAR, CH_EM, CH_ARROW, size[BYTE_W-1:0], cmd};
            cks = size[BYTE_W-1:0] ^ cmd;
            for (i = 0; i < size; i++)
            begin
                b = BYTE_W'($urandom);
                burst.push_back(b);
                cks = cks ^ b;
            end
            // some checksums corrupted on purpose
            if ($urandom_range(0, 99) < 15)
                cks = cks ^ 8'($urandom_range(1, 255));
            burst.push_back(cks);
            counted = burst.size();
        end
        else if (pick < 80)
        begin
            // size above the effective limit
            size = $urandom_range(eff_limit + 1, 255);
            burst = '{CH_DOLLAR, CH_EM, CH_ARROW, size[BYTE_W-1:0]};
            counted = burst.size();
        end
        else if (pick < 90)
        begin
            // header broken after one or two good characters
            k = $urandom_range(1, 2);
            burst.push_back(CH_DOLLAR);
            if (k == 2)
                burst.push_back(CH_EM);
            b = BYTE_W'($urandom);
            if (b == ((k == 1) ? CH_EM : CH_ARROW))
                b = b ^ 8'h01;
            burst.push_back(b);
            counted = burst.size();
        end
        else
        begin
            // line noise while idle
            k = $urandom_range(1, 4);
            for (i = 0; i < k; i++)
                burst.push_back(8'($urandom));
            counted = 0;
        end
    endtask

    // stimulus and end of run
    initial
    begin
        logic [LEN_W-1:0] limits [NUM_PHASES];
        int unsigned      counted;
        int unsigned      budget;
        bit               no_gaps;
        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_wdata     <= '0;
        rx_ch.valid   <= 1'b0;
        rx_ch.rx_byte <= '0;
        // shadow state after reset
        phase_m = PH_IDLE;
        xor_m   = '0;
        cmd_m   = '0;
        len_m   = '0;
        fill_m  = '0;
        limit_m = DEPTH_LEN;
        // all ones, all zeros, smallest nonzero, exact depth, random, small
        limits    = '{6'd63, 6'd0, 6'd1, 6'd32, 6'd0, 6'd9};
        limits[4] = LEN_W'($urandom_range(2, 31));
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table at the reset limit
        foreach (DIRECTED[i])
            drive_byte(DIRECTED[i].rx_byte, DIRECTED[i].typed, DIRECTED[i].has_result,
                       DIRECTED[i].res, 1'b0);

        // random phases, one size_limit setting each
        foreach (limits[p])
        begin
            write_size_limit(limits[p]);
            budget = 0;
            while (budget < PHASE_ITEMS)
            begin
                queue_random_sequence(counted);
                // about one sequence in four goes through back to back
                no_gaps = ($urandom_range(0, 3) == 0);
                foreach (burst[j])
                    drive_byte(burst[j], 1'b0, 1'b0, '0, no_gaps);
                budget += counted;
            end
        end

        // drain: everything owed must arrive, then a quiet tail for strays
        rx_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // result sink: runs of ready, long ones at times, broken by random stalls
    initial
    begin
        int unsigned run;
        int unsigned stall;
        res_ch.ready <= 1'b0;
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 3) == 0)
                run = $urandom_range(20, 80);
            else
                run = $urandom_range(1, 6);
            stall = pick_idle_cycles();
            res_ch.ready <= 1'b1;
            repeat (run) @(posedge clk);
            if (stall != 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    function automatic void check_field(input string name, input logic [BYTE_W-1:0] want,
                                        input logic [BYTE_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    // each result item against the oldest one owed
    always @(posedge clk)
    begin
        parse_result_t want;
        if (rst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with nothing owed: kind %0d command 0x%0h length %0d data 0x%0h",
                       res_ch.kind, res_ch.command, res_ch.length, res_ch.data);
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("kind", BYTE_W'(want.kind), BYTE_W'(res_ch.kind));
                check_field("command", want.command, res_ch.command);
                check_field("length", BYTE_W'(want.length), BYTE_W'(res_ch.length));
                check_field("data", want.data, res_ch.data);
                check_field("last", BYTE_W'(want.last), BYTE_W'(res_ch.last));
            end
        end
    end

    // watchdog: too long with no item moving on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (rx_ch.valid === 1'b1 && rx_ch.ready === 1'b1) ||
            (res_ch.valid === 1'b1 && res_ch.ready === 1'b1))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
